FILE: hw/rtl/msep_pkg.sv
// Shared types and constants for the MIDI stream event parser.
// No dependencies.
package msep_pkg;

    typedef enum logic [1:0] {
        KIND_NOTE_ON  = 2'd0,
        KIND_NOTE_OFF = 2'd1,
        KIND_BEND     = 2'd2,
        KIND_CONTROL  = 2'd3
    } event_kind_t;

    typedef logic [3:0] nibble_t;
    typedef logic [6:0] data7_t;

    // High nibbles of the channel voice messages that produce events.
    localparam nibble_t STATUS_NOTE_ON  = 4'b1001;
    localparam nibble_t STATUS_NOTE_OFF = 4'b1000;
    localparam nibble_t STATUS_BEND     = 4'b1110;
    localparam nibble_t STATUS_CONTROL  = 4'b1011;

    // Marker bit that every status nibble carries.
    localparam nibble_t STATUS_MARK     = 4'b1000;
    localparam nibble_t NIBBLE_MASK     = 4'hF;

    // Reset value of the channel filter: negative, so every channel passes.
    localparam logic signed [4:0] FILTER_ALL = -5'sd1;

endpackage

FILE: hw/rtl/midi_stream_event_parser.sv
// MIDI stream event parser: top level, a single module.
// Depends on msep_pkg for event kinds and status nibble constants.
//
// Usage
//   Packet bytes enter on the s_ channel one transfer at a time, with
//   s_packet_end high on the last byte of a packet. A byte with bit 7 set is
//   held back and becomes the running status only if a data byte follows,
//   so header and timestamp bytes are passed over. Data bytes pair up under
//   the running status; a lone data byte followed by a status byte or by the
//   end of the packet goes out with a second byte of zero. Note-on, note-off,
//   pitch-bend and control-change events whose channel passes the filter
//   appear as transfers on the m_ channel; other input bytes give nothing.
//   The cfg_ channel writes the signed channel filter (negative passes every
//   channel); it is always ready and should be written only while idle.
// Timing
//   Each accepted byte is decoded in the cycle it is accepted and its event,
//   if any, is valid on the m_ channel in the next cycle. One byte can be
//   accepted every cycle while m_ready is high: the single output register
//   is refilled in the same cycle that the receiver takes its contents.
// Reset and stalls
//   Reset clears the parser state, empties the output register and sets the
//   filter to pass all channels. While the receiver holds m_ready low with a
//   result waiting, s_ready stays low and the input stalls.
module midi_stream_event_parser (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic signed [4:0]      cfg_channel_filter,
    // Input byte channel
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_data_byte,
    input  logic                   s_packet_end,
    // Result channel
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [1:0]             m_event_kind,
    output logic [3:0]             m_event_channel,
    output msep_pkg::data7_t       m_first_data,
    output msep_pkg::data7_t       m_second_data
);
    import msep_pkg::*;

    logic signed [4:0] filter_reg;

    // Parser state.
    logic        held_valid_reg,    held_valid_next;
    data7_t      held_bits_reg,     held_bits_next;
    logic        pend_valid_reg,    pend_valid_next;
    data7_t      pend_value_reg,    pend_value_next;
    nibble_t     run_status_reg,    run_status_next;
    nibble_t     run_channel_reg,   run_channel_next;

    // Output register.
    logic        out_valid_reg,     out_valid_next;
    event_kind_t out_kind_reg,      out_kind_next;
    nibble_t     out_channel_reg,   out_channel_next;
    data7_t      out_first_reg,     out_first_next;
    data7_t      out_second_reg,    out_second_next;

    logic        accept;
    logic        is_status;
    data7_t      byte_low;
    nibble_t     eff_status;
    nibble_t     eff_channel;
    logic        want_emit;
    data7_t      p1;
    data7_t      p2;
    logic        chan_pass;
    logic        kind_ok;
    event_kind_t kind;

    assign cfg_ready = 1'b1;
    assign s_ready   = !out_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign is_status = s_data_byte[7];
    assign byte_low  = s_data_byte[6:0];

    // A data byte promotes a held status before the event is formed; a status
    // byte flushes any lone data byte under the old running status.
    always_comb begin
        if (!is_status && held_valid_reg) begin
            eff_status  = STATUS_MARK | {1'b0, held_bits_reg[6:4]};
            eff_channel = held_bits_reg[3:0] & NIBBLE_MASK;
        end else begin
            eff_status  = run_status_reg;
            eff_channel = run_channel_reg;
        end
    end

    always_comb begin
        want_emit = 1'b0;
        p1        = pend_value_reg;
        p2        = '0;
        if (is_status) begin
            want_emit = pend_valid_reg;
        end else if (pend_valid_reg) begin
            want_emit = 1'b1;
            p2        = byte_low;
        end else if (s_packet_end) begin
            want_emit = 1'b1;
            p1        = byte_low;
        end
    end

    assign chan_pass = filter_reg[4] || (filter_reg[3:0] == eff_channel);

    always_comb begin
        kind_ok = 1'b1;
        case (eff_status)
            STATUS_NOTE_ON:  kind = KIND_NOTE_ON;
            STATUS_NOTE_OFF: kind = KIND_NOTE_OFF;
            STATUS_BEND:     kind = KIND_BEND;
            STATUS_CONTROL:  kind = KIND_CONTROL;
            default: begin
                kind    = KIND_NOTE_ON;
                kind_ok = 1'b0;
            end
        endcase
    end

    // Next parser state.
    always_comb begin
        held_valid_next  = held_valid_reg;
        held_bits_next   = held_bits_reg;
        pend_valid_next  = pend_valid_reg;
        pend_value_next  = pend_value_reg;
        run_status_next  = run_status_reg;
        run_channel_next = run_channel_reg;
        if (accept) begin
            if (is_status) begin
                pend_valid_next = 1'b0;
                pend_value_next = '0;
                held_valid_next = 1'b1;
                held_bits_next  = byte_low;
            end else begin
                held_valid_next  = 1'b0;
                held_bits_next   = '0;
                run_status_next  = eff_status;
                run_channel_next = eff_channel;
                if (pend_valid_reg) begin
                    pend_valid_next = 1'b0;
                    pend_value_next = '0;
                end else if (!s_packet_end) begin
                    pend_valid_next = 1'b1;
                    pend_value_next = byte_low;
                end
            end
            // Every packet starts from a clean stream.
            if (s_packet_end) begin
                held_valid_next  = 1'b0;
                held_bits_next   = '0;
                pend_valid_next  = 1'b0;
                pend_value_next  = '0;
                run_status_next  = '0;
                run_channel_next = '0;
            end
        end
    end

    // Next output register contents.
    always_comb begin
        out_valid_next   = out_valid_reg && !m_ready;
        out_kind_next    = out_kind_reg;
        out_channel_next = out_channel_reg;
        out_first_next   = out_first_reg;
        out_second_next  = out_second_reg;
        if (accept) begin
            out_valid_next   = want_emit && chan_pass && kind_ok;
            out_kind_next    = kind;
            out_channel_next = eff_channel;
            out_first_next   = p1;
            out_second_next  = (kind == KIND_BEND) ? data7_t'(0) : p2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_reg      <= FILTER_ALL;
            held_valid_reg  <= 1'b0;
            held_bits_reg   <= '0;
            pend_valid_reg  <= 1'b0;
            pend_value_reg  <= '0;
            run_status_reg  <= '0;
            run_channel_reg <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                filter_reg <= cfg_channel_filter;
            end
            held_valid_reg  <= held_valid_next;
            held_bits_reg   <= held_bits_next;
            pend_valid_reg  <= pend_valid_next;
            pend_value_reg  <= pend_value_next;
            run_status_reg  <= run_status_next;
            run_channel_reg <= run_channel_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        out_kind_reg    <= out_kind_next;
        out_channel_reg <= out_channel_next;
        out_first_reg   <= out_first_next;
        out_second_reg  <= out_second_next;
    end

    assign m_valid         = out_valid_reg;
    assign m_event_kind    = out_kind_reg;
    assign m_event_channel = out_channel_reg;
    assign m_first_data    = out_first_reg;
    assign m_second_data   = out_second_reg;

endmodule

FILE: dv/midi_stream_event_parser_checker.sv
// Event checker for the MIDI stream event parser: watches the byte, config and
// event channels, predicts the parser's events and compares them field by field.
// Depends on msep_pkg for event kinds, status nibbles and the filter reset value.
module msep_event_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic signed [4:0] cfg_channel_filter,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [7:0]        s_data_byte,
    input  logic              s_packet_end,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [1:0]        m_event_kind,
    input  logic [3:0]        m_event_channel,
    input  msep_pkg::data7_t  m_first_data,
    input  msep_pkg::data7_t  m_second_data,
    output int                mismatch_count,
    output int                events_pending
);
    import msep_pkg::*;

    typedef struct packed {
        event_kind_t kind;
        nibble_t     channel;
        data7_t      first;
        data7_t      second;
    } midi_event_t;

    logic signed [4:0] filter_q = FILTER_ALL;
    logic              held_valid = 1'b0;
    data7_t            held_bits = '0;
    logic              lone_valid = 1'b0;
    data7_t            lone_value = '0;
    nibble_t           run_status = '0;
    nibble_t           run_channel = '0;
    midi_event_t       expected_events[$];
    int                errors = 0;

    assign mismatch_count = errors;

    function automatic void clear_parse();
        held_valid  = 1'b0;
        held_bits   = '0;
        lone_valid  = 1'b0;
        lone_value  = '0;
        run_status  = '0;
        run_channel = '0;
    endfunction

    // Builds the event for the current running status; returns 0 when the
    // channel is filtered out or the status nibble carries no event.
    function automatic logic make_event(input data7_t d1, input data7_t d2,
                                        output midi_event_t ev);
        ev = '0;
        if (!filter_q[4] && filter_q[3:0] != run_channel) return 1'b0;
        ev.channel = run_channel;
        ev.first   = d1;
        ev.second  = d2;
        case (run_status)
            STATUS_NOTE_ON:  ev.kind = KIND_NOTE_ON;
            STATUS_NOTE_OFF: ev.kind = KIND_NOTE_OFF;
            STATUS_BEND: begin
                ev.kind   = KIND_BEND;
                ev.second = '0;
            end
            STATUS_CONTROL:  ev.kind = KIND_CONTROL;
            default:         return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic void take_byte(input logic [7:0] b, input logic last);
        midi_event_t ev;
        logic        hit;
        hit = 1'b0;
        if (b[7]) begin
            if (lone_valid) begin
                hit        = make_event(lone_value, '0, ev);
                lone_valid = 1'b0;
                lone_value = '0;
            end
            held_valid = 1'b1;
            held_bits  = b[6:0];
        end else begin
            if (held_valid) begin
                run_status  = STATUS_MARK | {1'b0, held_bits[6:4]};
                run_channel = held_bits[3:0];
                held_valid  = 1'b0;
                held_bits   = '0;
            end
            if (lone_valid) begin
                hit        = make_event(lone_value, b[6:0], ev);
                lone_valid = 1'b0;
                lone_value = '0;
            end else if (last) begin
                hit = make_event(b[6:0], '0, ev);
            end else begin
                lone_valid = 1'b1;
                lone_value = b[6:0];
            end
        end
        if (last) clear_parse();
        if (hit) expected_events.push_back(ev);
    endfunction

    function automatic void report_field(input string field, input logic [7:0] want,
                                         input logic [7:0] got);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        errors++;
    endfunction

    always @(posedge aclk) begin
        midi_event_t want;
        if (!aresetn) begin
            filter_q = FILTER_ALL;
            clear_parse();
            expected_events.delete();
        end else begin
            if (cfg_valid && cfg_ready) filter_q = cfg_channel_filter;
            // An event is registered in the parser after its byte, so compare before predicting.
            if (m_valid && m_ready) begin
                if (expected_events.size() == 0) begin
                    $display("%0t: unexpected event, actual kind %0h channel %0h data %0h %0h",
                             $time, m_event_kind, m_event_channel, m_first_data,
                             m_second_data);
                    errors++;
                end else begin
                    want = expected_events.pop_front();
                    if (m_event_kind !== want.kind)
                        report_field("event_kind", want.kind, m_event_kind);
                    if (m_event_channel !== want.channel)
                        report_field("event_channel", want.channel, m_event_channel);
                    if (m_first_data !== want.first)
                        report_field("first_data", want.first, m_first_data);
                    if (m_second_data !== want.second)
                        report_field("second_data", want.second, m_second_data);
                end
            end
            if (s_valid && s_ready) take_byte(s_data_byte, s_packet_end);
        end
        events_pending = expected_events.size();
    end

endmodule

FILE: dv/midi_stream_event_parser_tb.sv
// Testbench top for the MIDI stream event parser: clock, reset, packet stimulus,
// receiver back-pressure and the final verdict.
// Depends on msep_pkg, midi_stream_event_parser and msep_event_checker.
module midi_stream_event_parser_tb;
    import msep_pkg::*;

    // The run is cut off here; the slowest legal run stays far below it.
    localparam int CYCLE_LIMIT     = 500000;
    // The parser registers each event after its byte, so a few idle cycles suffice
    // to be sure that nothing is still on its way.
    localparam int DRAIN_CYCLES    = 4;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int PHASE_ITEMS     = 215;

    logic              aclk;
    logic              aresetn = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic signed [4:0] cfg_channel_filter = FILTER_ALL;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [7:0]        s_data_byte = '0;
    logic              s_packet_end = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [1:0]        m_event_kind;
    logic [3:0]        m_event_channel;
    data7_t            m_first_data;
    data7_t            m_second_data;

    int                mismatch_count;
    int                events_pending;
    int                cycle_count = 0;
    int                items_sent = 0;
    // While set, neither side idles at random; it is redrawn for every packet.
    logic              quiet_mode = 1'b0;
    // Raised by the stimulus to ask the receiver for one long hold-off.
    logic              long_hold_req = 1'b0;
    logic [7:0]        pkt_bytes[$];

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    midi_stream_event_parser u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_channel_filter (cfg_channel_filter),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_data_byte        (s_data_byte),
        .s_packet_end       (s_packet_end),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_event_kind       (m_event_kind),
        .m_event_channel    (m_event_channel),
        .m_first_data       (m_first_data),
        .m_second_data      (m_second_data)
    );

    msep_event_checker u_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_channel_filter (cfg_channel_filter),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_data_byte        (s_data_byte),
        .s_packet_end       (s_packet_end),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_event_kind       (m_event_kind),
        .m_event_channel    (m_event_channel),
        .m_first_data       (m_first_data),
        .m_second_data      (m_second_data),
        .mismatch_count     (mismatch_count),
        .events_pending     (events_pending)
    );

    // Watchdog: a hung handshake or a lost event ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d events outstanding", $time, events_pending);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Idle lengths: mostly short, now and then a long one.
    function automatic int pick_idle();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // The receiver decides m_ready once per falling edge. It stalls at random
    // unless the current packet runs in quiet mode, and it honors a request
    // for a long hold-off by counting the cycles itself, so the sender keeps
    // offering bytes while the parser's output register stays full.
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left    = HOLD_OFF_CYCLES;
            end else if (stall_left == 0 && !quiet_mode && $urandom_range(0, 99) < 20) begin
                stall_left = pick_idle();
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Offers one byte and returns once the transfer has happened. Payload and
    // valid change only on the falling edge; acceptance is seen at the rising one.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = (quiet_mode || $urandom_range(0, 99) < 65) ? 0 : pick_idle();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_data_byte  <= b;
        s_packet_end <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // Sends the bytes collected in pkt_bytes, flagging the last one.
    task automatic send_packet();
        foreach (pkt_bytes[i]) send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
    endtask

    // Drops valid and waits until every predicted event has come out.
    task automatic wait_for_drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (events_pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // The filter is only changed between packets with the parser idle.
    task automatic write_filter(input logic signed [4:0] value);
        wait_for_drain();
        @(negedge aclk);
        cfg_valid          <= 1'b1;
        cfg_channel_filter <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // A packet shaped like real traffic: a header byte, then messages made of
    // a timestamp, usually a status byte, and one to four data bytes. Missing
    // status bytes exercise running status, odd data counts leave lone bytes,
    // and once in a while the packet ends on a status byte.
    task automatic build_midi_packet();
        int      n_msgs;
        int      n_data;
        nibble_t hi;
        pkt_bytes.delete();
        pkt_bytes.push_back({2'b10, 6'($urandom)});
        n_msgs = $urandom_range(1, 4);
        repeat (n_msgs) begin
            pkt_bytes.push_back({1'b1, 7'($urandom)});
            if ($urandom_range(0, 9) < 8) begin
                case ($urandom_range(0, 4))
                    0:       hi = STATUS_NOTE_ON;
                    1:       hi = STATUS_NOTE_OFF;
                    2:       hi = STATUS_BEND;
                    3:       hi = STATUS_CONTROL;
                    default: hi = STATUS_MARK | nibble_t'($urandom_range(0, 7));
                endcase
                pkt_bytes.push_back({hi, 4'($urandom)});
            end
            n_data = $urandom_range(1, 4);
            repeat (n_data) pkt_bytes.push_back({1'b0, 7'($urandom)});
        end
        if ($urandom_range(0, 9) == 0) pkt_bytes.push_back({1'b1, 7'($urandom)});
    endtask

    // Noise: a short packet of arbitrary bytes.
    task automatic build_noise_packet();
        int n_bytes;
        pkt_bytes.delete();
        n_bytes = $urandom_range(1, 6);
        repeat (n_bytes) pkt_bytes.push_back(8'($urandom));
    endtask

    initial begin : stimulus
        logic signed [4:0] filter_plan [6];
        int                target;

        // Filter settings per random phase: both ends of the positive range,
        // the most negative value, a channel in between, all-pass, and a
        // random negative value that must also pass every channel.
        filter_plan[0] = 5'sd0;
        filter_plan[1] = 5'sd15;
        filter_plan[2] = 5'sb10000;
        filter_plan[3] = 5'($urandom_range(1, 14));
        filter_plan[4] = FILTER_ALL;
        filter_plan[5] = -5'($urandom_range(2, 15));

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed packets with the filter at its reset value. The first one
        // walks through a header and timestamp pair, a note-on at the data
        // extremes on channel 15, a lone data byte cut short by a status byte,
        // control change, a status byte followed by another status byte, an
        // unsupported status whose lone byte is dropped, pitch bend, and it
        // ends on a status byte that must be dropped.
        pkt_bytes = '{8'hFF, 8'h80, 8'h9F, 8'h00, 8'h7F, 8'h8A, 8'h11, 8'hB3, 8'h07,
                      8'h64, 8'hE1, 8'hA2, 8'h05, 8'hC0, 8'hF0, 8'hEE, 8'h2A, 8'h55,
                      8'h91};
        send_packet();
        // Data bytes with no status in the packet give nothing.
        pkt_bytes = '{8'h12, 8'h34, 8'h56};
        send_packet();
        // A lone data byte that ends the packet goes out with a zero partner.
        pkt_bytes = '{8'hB0, 8'h7F};
        send_packet();

        for (int ph = 0; ph < 6; ph++) begin
            write_filter(filter_plan[ph]);
            // Two phases start with a long receiver hold-off to fill the parser.
            if (ph == 1 || ph == 4) long_hold_req = 1'b1;
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                quiet_mode = ($urandom_range(0, 9) == 0);
                if ($urandom_range(0, 9) == 0) build_noise_packet();
                else build_midi_packet();
                send_packet();
            end
            quiet_mode = 1'b0;
        end

        wait_for_drain();
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/msep_pkg.sv
hw/rtl/midi_stream_event_parser.sv
dv/midi_stream_event_parser_checker.sv
dv/midi_stream_event_parser_tb.sv
